@@ rtl/core/chunk_reassembly_buffer_assert.svh @@
// ----------------------------------------------------------------------------
// chunk reassembly buffer assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef CHUNK_REASSEMBLY_BUFFER_ASSERT_SVH
`define CHUNK_REASSEMBLY_BUFFER_ASSERT_SVH

// antecedent, then consequent in the next cycle, outside reset
`define CRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crb assertion failed");

// antecedent, then consequent after an added delay, outside reset
`define CRB_ASSERT_LATER(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("crb assertion failed");

// antecedent, then consequent in the next cycle, checked through reset
`define CRB_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crb assertion failed");

`endif

@@ rtl/core/crb_pkg.sv @@
// ----------------------------------------------------------------------------
// crb_pkg
// types and constants of the chunk reassembly buffer
// ----------------------------------------------------------------------------
package crb_pkg;

  // width of the generation tag kept beside every payload byte
  localparam int EPOCH_W = 12;

  typedef enum logic [1:0] {
    FUNC_HEADER = 2'd0,
    FUNC_DATA   = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } crb_func_t;

  typedef enum logic [3:0] {
    STS_HDR_OK    = 4'd0,
    STS_STORED    = 4'd1,
    STS_CHUNK     = 4'd2,
    STS_COMPLETE  = 4'd3,
    STS_BAD_INDEX = 4'd4,
    STS_BOUNDS    = 4'd5,
    STS_SHORT     = 4'd6,
    STS_CAPACITY  = 4'd7,
    STS_IGNORED   = 4'd8,
    STS_READ      = 4'd9
  } crb_status_t;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_RUN,
    CS_READ
  } crb_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] msg_sequence;
    logic [15:0] chunk_number;
    logic [15:0] chunk_total;
    logic [15:0] byte_offset;
    logic [10:0] chunk_length;
    logic [15:0] message_length;
    logic [10:0] bytes_available;
    logic [7:0]  data_byte;
    logic [13:0] read_address;
  } crb_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  read_byte;
    logic [8:0]  chunks_received;
    logic [14:0] assembly_size;
    logic [31:0] assembly_sequence;
  } crb_result_t;

  typedef struct packed {
    logic take;
    logic load_read;
    logic clear_step;
  } crb_cmd_t;

  typedef struct packed {
    logic is_read;
    logic wrap;
    logic clear_last;
    logic out_free;
  } crb_stat_t;

endpackage

@@ rtl/core/crb_if.sv @@
// ----------------------------------------------------------------------------
// crb channel interfaces
// item channel and result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface crb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] msg_sequence;
  logic [15:0] chunk_number;
  logic [15:0] chunk_total;
  logic [15:0] byte_offset;
  logic [10:0] chunk_length;
  logic [15:0] message_length;
  logic [10:0] bytes_available;
  logic [7:0]  data_byte;
  logic [13:0] read_address;

  modport source (
    output valid, func, msg_sequence, chunk_number, chunk_total, byte_offset,
           chunk_length, message_length, bytes_available, data_byte, read_address,
    input  ready
  );
  modport sink (
    input  valid, func, msg_sequence, chunk_number, chunk_total, byte_offset,
           chunk_length, message_length, bytes_available, data_byte, read_address,
    output ready
  );
endinterface

interface crb_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  read_byte;
  logic [8:0]  chunks_received;
  logic [14:0] assembly_size;
  logic [31:0] assembly_sequence;

  modport source (
    output valid, status, read_byte, chunks_received, assembly_size, assembly_sequence,
    input  ready
  );
  modport sink (
    input  valid, status, read_byte, chunks_received, assembly_size, assembly_sequence,
    output ready
  );
endinterface

@@ rtl/core/chunk_reassembly_buffer.sv @@
// ----------------------------------------------------------------------------
// chunk_reassembly_buffer
// rebuilds one message from numbered chunks and serves payload byte reads
//
//   channel  dir  handshake      payload
//   in_bus   in   valid/ready    func, header fields, data_byte, read_address
//   out_bus  out  valid/ready    status, read_byte, counters, sequence
//
// header, data byte and unused items go straight to the result register;
// a read passes the registered memory read port first and stalls the input
// after reset a clearing pass over all MAX_PAYLOAD words runs before the first beat;
// every 4095th restart starts another pass over all words (tag wrap)
// the result register lets a new beat in while it is drained the same cycle
// ----------------------------------------------------------------------------
module chunk_reassembly_buffer #(
  parameter int MAX_PAYLOAD = 16384,
  parameter int MAX_CHUNKS  = 256
) (
  input logic       clk,
  input logic       rst_n,
  crb_in_if.sink    in_bus,
  crb_out_if.source out_bus
);

  crb_pkg::crb_item_t   item;
  crb_pkg::crb_result_t result;
  crb_pkg::crb_cmd_t    cmd;
  crb_pkg::crb_stat_t   stat;
  logic                 in_ready;
  logic                 out_valid;

  always_comb begin
    item.func            = in_bus.func;
    item.msg_sequence    = in_bus.msg_sequence;
    item.chunk_number    = in_bus.chunk_number;
    item.chunk_total     = in_bus.chunk_total;
    item.byte_offset     = in_bus.byte_offset;
    item.chunk_length    = in_bus.chunk_length;
    item.message_length  = in_bus.message_length;
    item.bytes_available = in_bus.bytes_available;
    item.data_byte       = in_bus.data_byte;
    item.read_address    = in_bus.read_address;
  end

  crb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  crb_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_CHUNKS  (MAX_CHUNKS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .cmd       (cmd),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .out_valid (out_valid),
    .result    (result)
  );

  assign in_bus.ready              = in_ready;
  assign out_bus.valid             = out_valid;
  assign out_bus.status            = result.status;
  assign out_bus.read_byte         = result.read_byte;
  assign out_bus.chunks_received   = result.chunks_received;
  assign out_bus.assembly_size     = result.assembly_size;
  assign out_bus.assembly_sequence = result.assembly_sequence;

endmodule

@@ rtl/core/crb_ctrl.sv @@
// ----------------------------------------------------------------------------
// crb_ctrl
// sequencer: clearing pass, item acceptance and the read data cycle
// ----------------------------------------------------------------------------
module crb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  crb_pkg::crb_stat_t  stat,
  output logic                in_ready,
  output crb_pkg::crb_cmd_t   cmd
);

  crb_pkg::crb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crb_pkg::CS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crb_pkg::CS_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = crb_pkg::CS_RUN;
        end
      end
      crb_pkg::CS_RUN: begin
        if (cmd.take) begin
          priority if (stat.is_read) begin
            state_nxt = crb_pkg::CS_READ;
          end else if (stat.wrap) begin
            state_nxt = crb_pkg::CS_CLEAR;
          end
        end
      end
      crb_pkg::CS_READ: begin
        state_nxt = crb_pkg::CS_RUN;
      end
      default: begin
        state_nxt = crb_pkg::CS_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state_r == crb_pkg::CS_RUN) && stat.out_free;
    cmd.take       = in_valid && in_ready;
    cmd.load_read  = (state_r == crb_pkg::CS_READ);
    cmd.clear_step = (state_r == crb_pkg::CS_CLEAR);
  end

endmodule

@@ rtl/core/crb_dpath.sv @@
// ----------------------------------------------------------------------------
// crb_dpath
// assembly state, chunk bitmap, tagged payload memory and result register
// ----------------------------------------------------------------------------
module crb_dpath #(
  parameter int MAX_PAYLOAD = 16384,
  parameter int MAX_CHUNKS  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crb_pkg::crb_item_t    item,
  input  crb_pkg::crb_cmd_t     cmd,
  input  logic                  out_ready,
  output crb_pkg::crb_stat_t    stat,
  output logic                  out_valid,
  output crb_pkg::crb_result_t  result
);

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int NW = $clog2(MAX_CHUNKS + 1);
  localparam int EW = crb_pkg::EPOCH_W;
  localparam int MW = EW + 8;

  // assembly state
  logic [31:0]           cur_seq_r, cur_seq_nxt;
  logic                  active_r, active_nxt;
  logic [15:0]           total_r, total_nxt;
  logic [NW-1:0]         expect_r, expect_nxt;
  logic [MAX_CHUNKS-1:0] seen_r, seen_nxt;
  logic [NW-1:0]         count_r, count_nxt;
  logic [15:0]           wp_r, wp_nxt;
  logic [10:0]           left_r, left_nxt;
  logic                  taking_r, taking_nxt;
  logic [CW-1:0]         open_r, open_nxt;
  logic [EW-1:0]         epoch_r, epoch_nxt;
  logic [AW-1:0]         clr_ptr_r, clr_ptr_nxt;

  // payload memory, each word is {tag, byte}
  logic [MW-1:0]         mem [MAX_PAYLOAD];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [MW-1:0]         mem_wd;
  logic                  rd_en;
  logic [MW-1:0]         rd_word_r;
  logic                  rd_ok_r;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  crb_pkg::crb_result_t  res_r, res_nxt;

  // header evaluation
  logic                  is_hdr, is_data, is_read;
  logic                  restart, over;
  logic [15:0]           base_total;
  logic [NW-1:0]         base_exp, base_cnt;
  logic [MAX_CHUNKS-1:0] base_seen;
  logic                  idx_ok, bound_bad, short_bad;
  logic [16:0]           chunk_end;
  logic                  wp_in_range;
  logic [10:0]           left_dec;

  // chunk completion
  logic [CW-1:0]         fin_idx;
  logic [MAX_CHUNKS-1:0] fin_seen_in, fin_seen;
  logic [NW-1:0]         fin_cnt_in, fin_cnt, fin_exp;
  logic                  fin_done;

  crb_pkg::crb_status_t  sts;
  logic                  rd_hit;

  always_comb begin
    is_hdr  = (item.func == crb_pkg::FUNC_HEADER);
    is_data = (item.func == crb_pkg::FUNC_DATA);
    is_read = (item.func == crb_pkg::FUNC_READ);

    restart = !active_r || (item.msg_sequence != cur_seq_r);
    over    = (32'(item.message_length) > 32'(MAX_PAYLOAD))
           || (32'(item.chunk_total) > 32'(MAX_CHUNKS));

    base_total = restart ? item.message_length : total_r;
    base_exp   = restart ? NW'(item.chunk_total) : expect_r;
    base_cnt   = restart ? '0 : count_r;
    base_seen  = restart ? '0 : seen_r;

    idx_ok    = 32'(item.chunk_number) < 32'(base_exp);
    chunk_end = 17'(item.byte_offset) + 17'(item.chunk_length);
    bound_bad = chunk_end > 17'(base_total);
    short_bad = item.bytes_available < item.chunk_length;

    wp_in_range = 32'(wp_r) < 32'(MAX_PAYLOAD);
    left_dec    = (left_r == '0) ? '0 : left_r - 11'd1;

    fin_idx     = is_hdr ? CW'(item.chunk_number) : open_r;
    fin_seen_in = is_hdr ? base_seen : seen_r;
    fin_cnt_in  = is_hdr ? base_cnt : count_r;
    fin_exp     = is_hdr ? base_exp : expect_r;
    fin_seen    = fin_seen_in;
    fin_seen[fin_idx] = 1'b1;
    fin_cnt     = fin_cnt_in + NW'(!fin_seen_in[fin_idx]);
    fin_done    = (fin_cnt == fin_exp);
  end

  // next state of the assembly
  always_comb begin
    cur_seq_nxt = cur_seq_r;
    active_nxt  = active_r;
    total_nxt   = total_r;
    expect_nxt  = expect_r;
    seen_nxt    = seen_r;
    count_nxt   = count_r;
    wp_nxt      = wp_r;
    left_nxt    = left_r;
    taking_nxt  = taking_r;
    open_nxt    = open_r;
    epoch_nxt   = epoch_r;
    clr_ptr_nxt = clr_ptr_r;
    sts         = crb_pkg::STS_IGNORED;
    mem_we      = 1'b0;
    mem_wa      = AW'(wp_r);
    mem_wd      = {epoch_r, item.data_byte};
    rd_en       = 1'b0;

    if (cmd.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clr_ptr_r;
      mem_wd = '0;
      if (stat.clear_last) begin
        clr_ptr_nxt = '0;
        epoch_nxt   = EW'(1);
      end else begin
        clr_ptr_nxt = clr_ptr_r + AW'(1);
      end
    end

    if (cmd.take) begin
      unique case (item.func)
        crb_pkg::FUNC_HEADER: begin
          taking_nxt = 1'b0;
          left_nxt   = '0;
          if (restart) begin
            cur_seq_nxt = item.msg_sequence;
            seen_nxt    = '0;
            count_nxt   = '0;
            epoch_nxt   = epoch_r + EW'(1);
            if (over) begin
              total_nxt  = '0;
              expect_nxt = '0;
              active_nxt = 1'b0;
            end else begin
              total_nxt  = item.message_length;
              expect_nxt = NW'(item.chunk_total);
              active_nxt = (item.chunk_total != '0);
            end
          end
          priority if (restart && over) begin
            sts = crb_pkg::STS_CAPACITY;
          end else if (!idx_ok) begin
            sts = crb_pkg::STS_BAD_INDEX;
          end else if (bound_bad) begin
            sts = crb_pkg::STS_BOUNDS;
          end else if (short_bad) begin
            sts = crb_pkg::STS_SHORT;
          end else begin
            open_nxt   = fin_idx;
            wp_nxt     = item.byte_offset;
            left_nxt   = item.chunk_length;
            taking_nxt = 1'b1;
            if (item.chunk_length == '0) begin
              taking_nxt = 1'b0;
              seen_nxt   = fin_seen;
              count_nxt  = fin_cnt;
              if (fin_done) begin
                active_nxt = 1'b0;
                sts        = crb_pkg::STS_COMPLETE;
              end else begin
                sts = crb_pkg::STS_CHUNK;
              end
            end else begin
              sts = crb_pkg::STS_HDR_OK;
            end
          end
        end
        crb_pkg::FUNC_DATA: begin
          if (taking_r) begin
            mem_we   = wp_in_range;
            wp_nxt   = wp_r + 16'd1;
            left_nxt = left_dec;
            if (left_dec == '0) begin
              taking_nxt = 1'b0;
              seen_nxt   = fin_seen;
              count_nxt  = fin_cnt;
              if (fin_done) begin
                active_nxt = 1'b0;
                sts        = crb_pkg::STS_COMPLETE;
              end else begin
                sts = crb_pkg::STS_CHUNK;
              end
            end else begin
              sts = crb_pkg::STS_STORED;
            end
          end
        end
        crb_pkg::FUNC_READ: begin
          rd_en = 1'b1;
          sts   = crb_pkg::STS_READ;
        end
        default: begin
          sts = crb_pkg::STS_IGNORED;
        end
      endcase
    end
  end

  // result register
  always_comb begin
    rd_hit        = rd_ok_r && (rd_word_r[MW-1:8] == epoch_r);
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    if (cmd.take && !is_read) begin
      out_valid_nxt             = 1'b1;
      res_nxt.status            = sts;
      res_nxt.read_byte         = '0;
      res_nxt.chunks_received   = 9'(count_nxt);
      res_nxt.assembly_size     = 15'(total_nxt);
      res_nxt.assembly_sequence = cur_seq_nxt;
    end else if (cmd.load_read) begin
      out_valid_nxt             = 1'b1;
      res_nxt.status            = crb_pkg::STS_READ;
      res_nxt.read_byte         = rd_hit ? rd_word_r[7:0] : 8'd0;
      res_nxt.chunks_received   = 9'(count_r);
      res_nxt.assembly_size     = 15'(total_r);
      res_nxt.assembly_sequence = cur_seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_word_r <= mem[AW'(item.read_address)];
      rd_ok_r   <= 32'(item.read_address) < 32'(MAX_PAYLOAD);
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_seq_r   <= '0;
      active_r    <= 1'b0;
      total_r     <= '0;
      expect_r    <= '0;
      seen_r      <= '0;
      count_r     <= '0;
      wp_r        <= '0;
      left_r      <= '0;
      taking_r    <= 1'b0;
      open_r      <= '0;
      epoch_r     <= EW'(1);
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_seq_r   <= cur_seq_nxt;
      active_r    <= active_nxt;
      total_r     <= total_nxt;
      expect_r    <= expect_nxt;
      seen_r      <= seen_nxt;
      count_r     <= count_nxt;
      wp_r        <= wp_nxt;
      left_r      <= left_nxt;
      taking_r    <= taking_nxt;
      open_r      <= open_nxt;
      epoch_r     <= epoch_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    stat.is_read    = is_read;
    stat.wrap       = is_hdr && restart && (epoch_r == '1);
    stat.clear_last = (32'(clr_ptr_r) == 32'(MAX_PAYLOAD - 1));
    stat.out_free   = !out_valid_r || out_ready;
    out_valid       = out_valid_r;
    result          = res_r;
  end

endmodule

@@ rtl/core/crb_checker.sv @@
// ----------------------------------------------------------------------------
// crb_checker
// port-level properties of the chunk reassembly buffer, bound to the top
// ----------------------------------------------------------------------------
`include "chunk_reassembly_buffer_assert.svh"

module crb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_status,
  input logic [7:0] out_read_byte
);

  logic in_beat, rd_beat, data_beat;

  assign in_beat   = in_valid && in_ready;
  assign rd_beat   = in_beat && (in_func == crb_pkg::FUNC_READ);
  assign data_beat = in_beat && (in_func == crb_pkg::FUNC_DATA);

  `CRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_read_byte))
  `CRB_ASSERT_NEXT_RST(a_clear_after_reset, !rst_n, !in_ready)
  `CRB_ASSERT_NEXT(a_read_stalls_input, rd_beat, !in_ready)
  `CRB_ASSERT_LATER(a_read_result, rd_beat, out_valid && (out_status == crb_pkg::STS_READ))
  `CRB_ASSERT_NEXT(a_data_result, data_beat, out_valid && ((out_status == crb_pkg::STS_STORED) || (out_status == crb_pkg::STS_CHUNK) || (out_status == crb_pkg::STS_COMPLETE) || (out_status == crb_pkg::STS_IGNORED)))

endmodule

bind chunk_reassembly_buffer crb_checker u_crb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .in_func       (in_bus.func),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_status    (out_bus.status),
  .out_read_byte (out_bus.read_byte)
);

@@ dv/tb_chunk_reassembly_buffer.sv @@
// ----------------------------------------------------------------------------
// tb_chunk_reassembly_buffer
// drives header, data, read and unused beats into the reassembly buffer
// under random idling and two long result stalls. Every result beat is
// checked field by field against an in-order prediction of the assembly
// state: bitmap, counters, written-byte marks and stored payload.
// ----------------------------------------------------------------------------
module tb_chunk_reassembly_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import crb_pkg::*;

  localparam int CAP          = 16384;
  localparam int CHUNK_CAP    = 256;
  localparam int RANDOM_ITEMS = 1150;

  logic clk;
  logic rst_n;

  crb_in_if  in_bus();
  crb_out_if out_bus();

  chunk_reassembly_buffer #(
    .MAX_PAYLOAD(CAP),
    .MAX_CHUNKS (CHUNK_CAP)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // predicted assembly state
  logic [31:0] msg_seq;
  bit          asm_active;
  int          msg_bytes;
  int          want_chunks;
  bit          seen[CHUNK_CAP];
  int          got_chunks;
  logic [7:0]  store[CAP];
  bit          written[CAP];
  bit          ever_stored[CAP];
  int          wr_ptr;
  int          left;
  bit          in_chunk;
  int          chunk_idx;

  crb_item_t   item_q[$];
  crb_result_t reply_q[$];
  int          stored_list[$];
  crb_item_t   on_wire;

  int items_made   = 0;
  int items_taken  = 0;
  int replies_done = 0;
  int counted      = 0;
  int errors       = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int status_hits[16];
  bit in_quiet     = 0;
  bit out_quiet    = 0;
  bit hold_off     = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int idle_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic crb_status_t close_chunk();
    in_chunk = 1'b0;
    if (chunk_idx < CHUNK_CAP && !seen[chunk_idx]) begin
      seen[chunk_idx] = 1'b1;
      got_chunks++;
    end
    if (got_chunks == want_chunks) begin
      asm_active = 1'b0;
      return STS_COMPLETE;
    end
    return STS_CHUNK;
  endfunction

  function automatic crb_result_t reassemble(crb_item_t it);
    crb_result_t r;
    crb_status_t st;
    bit          over;
    r    = '0;
    over = 1'b0;
    case (it.func)
      FUNC_HEADER: begin
        in_chunk = 1'b0;
        left     = 0;
        if (!asm_active || it.msg_sequence != msg_seq) begin
          msg_seq = it.msg_sequence;
          foreach (seen[i]) seen[i] = 1'b0;
          foreach (written[i]) written[i] = 1'b0;
          got_chunks = 0;
          if (it.message_length > CAP || it.chunk_total > CHUNK_CAP) begin
            msg_bytes   = 0;
            want_chunks = 0;
            asm_active  = 1'b0;
            over        = 1'b1;
          end else begin
            msg_bytes   = it.message_length;
            want_chunks = it.chunk_total;
            asm_active  = (it.chunk_total != 0);
          end
        end
        if (over) st = STS_CAPACITY;
        else if (int'(it.chunk_number) >= want_chunks) st = STS_BAD_INDEX;
        else if (int'(it.byte_offset) + int'(it.chunk_length) > msg_bytes) st = STS_BOUNDS;
        else if (it.bytes_available < it.chunk_length) st = STS_SHORT;
        else begin
          chunk_idx = it.chunk_number;
          wr_ptr    = it.byte_offset;
          left      = it.chunk_length;
          in_chunk  = 1'b1;
          st = (it.chunk_length == 0) ? close_chunk() : STS_HDR_OK;
        end
      end
      FUNC_DATA: begin
        if (!in_chunk) st = STS_IGNORED;
        else begin
          if (wr_ptr < CAP) begin
            store[wr_ptr]   = it.data_byte;
            written[wr_ptr] = 1'b1;
            if (!ever_stored[wr_ptr]) begin
              ever_stored[wr_ptr] = 1'b1;
              stored_list.push_back(wr_ptr);
            end
          end
          wr_ptr++;
          if (left > 0) left--;
          st = (left == 0) ? close_chunk() : STS_STORED;
        end
      end
      FUNC_READ: begin
        st = STS_READ;
        if (written[it.read_address]) r.read_byte = store[it.read_address];
      end
      default: st = STS_IGNORED;
    endcase
    r.status            = st;
    r.chunks_received   = got_chunks[8:0];
    r.assembly_size     = msg_bytes[14:0];
    r.assembly_sequence = msg_seq;
    return r;
  endfunction

  function automatic crb_item_t any_item();
    crb_item_t it;
    it.func            = 2'($urandom_range(0, 3));
    it.msg_sequence    = $urandom();
    it.chunk_number    = 16'($urandom());
    it.chunk_total     = 16'($urandom());
    it.byte_offset     = 16'($urandom());
    it.chunk_length    = 11'($urandom());
    it.message_length  = 16'($urandom());
    it.bytes_available = 11'($urandom());
    it.data_byte       = 8'($urandom());
    it.read_address    = 14'($urandom());
    return it;
  endfunction

  function automatic crb_item_t make_header(logic [31:0] seq, int num, int tot, int off,
                                            int len, int msz, int avail);
    crb_item_t it;
    it                 = any_item();
    it.func            = FUNC_HEADER;
    it.msg_sequence    = seq;
    it.chunk_number    = 16'(num);
    it.chunk_total     = 16'(tot);
    it.byte_offset     = 16'(off);
    it.chunk_length    = 11'(len);
    it.message_length  = 16'(msz);
    it.bytes_available = 11'(avail);
    return it;
  endfunction

  function automatic crb_item_t data_beat(int b);
    crb_item_t it;
    it           = any_item();
    it.func      = FUNC_DATA;
    it.data_byte = 8'(b);
    return it;
  endfunction

  function automatic crb_item_t read_beat(int a);
    crb_item_t it;
    it              = any_item();
    it.func         = FUNC_READ;
    it.read_address = 14'(a);
    return it;
  endfunction

  // only addresses that some data beat has already stored
  function automatic int pick_addr();
    return stored_list[$urandom_range(0, stored_list.size() - 1)];
  endfunction

  task automatic put(crb_item_t it, bit counts);
    while (items_made - items_taken > 48) @(posedge clk);
    item_q.push_back(it);
    items_made++;
    if (counts) counted++;
  endtask

  task automatic flag(string what);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got, int idx);
    if (got !== want)
      flag($sformatf("result %0d %s expected %0h got %0h", idx, name, want, got));
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        reply_q.push_back(reassemble(on_wire));
        items_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0 && !hold_off) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          on_wire = item_q.pop_front();
          in_bus.func            <= on_wire.func;
          in_bus.msg_sequence    <= on_wire.msg_sequence;
          in_bus.chunk_number    <= on_wire.chunk_number;
          in_bus.chunk_total     <= on_wire.chunk_total;
          in_bus.byte_offset     <= on_wire.byte_offset;
          in_bus.chunk_length    <= on_wire.chunk_length;
          in_bus.message_length  <= on_wire.message_length;
          in_bus.bytes_available <= on_wire.bytes_available;
          in_bus.data_byte       <= on_wire.data_byte;
          in_bus.read_address    <= on_wire.read_address;
          in_bus.valid           <= 1'b1;
          send_gap = (in_quiet || hold_off) ? 0 : idle_len();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    crb_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (reply_q.size() == 0) begin
          flag($sformatf("result %0d arrived with nothing outstanding", replies_done));
        end else begin
          want = reply_q.pop_front();
          compare_field("status", want.status, out_bus.status, replies_done);
          compare_field("read_byte", want.read_byte, out_bus.read_byte, replies_done);
          compare_field("chunks_received", want.chunks_received, out_bus.chunks_received,
                        replies_done);
          compare_field("assembly_size", want.assembly_size, out_bus.assembly_size,
                        replies_done);
          compare_field("assembly_sequence", want.assembly_sequence,
                        out_bus.assembly_sequence, replies_done);
        end
        status_hits[out_bus.status]++;
        replies_done++;
      end
      if (hold_off) begin
        out_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!out_quiet && $urandom_range(0, 3) == 0) recv_gap = idle_len();
      end
    end
  end

  // two long result stalls while the sender keeps offering
  initial begin
    for (int h = 0; h < 2; h++) begin
      while (items_taken < 300 + h * 500) @(posedge clk);
      hold_off <= 1'b1;
      repeat (250) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  initial begin
    crb_item_t   it;
    logic [31:0] seq;
    logic [31:0] last_seq;
    int          tot, msz, pick, n, c, tmp, reps, avail;
    int          off_a[CHUNK_CAP];
    int          len_a[CHUNK_CAP];
    int          order[CHUNK_CAP];

    msg_seq     = '0;
    asm_active  = 1'b0;
    msg_bytes   = 0;
    want_chunks = 0;
    got_chunks  = 0;
    wr_ptr      = 0;
    left        = 0;
    in_chunk    = 1'b0;
    chunk_idx   = 0;
    last_seq    = '0;
    foreach (seen[i]) seen[i] = 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    foreach (ever_stored[i]) ever_stored[i] = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;

    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.func            = '0;
    in_bus.msg_sequence    = '0;
    in_bus.chunk_number    = '0;
    in_bus.chunk_total     = '0;
    in_bus.byte_offset     = '0;
    in_bus.chunk_length    = '0;
    in_bus.message_length  = '0;
    in_bus.bytes_available = '0;
    in_bus.data_byte       = '0;
    in_bus.read_address    = '0;
    out_bus.ready          = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats
    put(data_beat(8'h3C), 1);
    it      = any_item();
    it.func = FUNC_NONE;
    put(it, 0);
    put(make_header(32'hFFFF_FFFF, CHUNK_CAP - 1, CHUNK_CAP, CAP - 1, 1, CAP, 2047), 1);
    put(data_beat(8'hFF), 1);
    put(make_header(32'hFFFF_FFFF, 0, CHUNK_CAP, 0, 2, CAP, 2), 1);
    put(data_beat(8'h00), 1);
    put(data_beat(8'hA5), 1);
    while (replies_done < items_made) @(posedge clk);
    put(read_beat(CAP - 1), 1);
    put(read_beat(0), 1);
    put(read_beat(1), 1);
    put(make_header(0, 0, CHUNK_CAP + 1, 0, 0, 100, 0), 1);
    put(make_header(1, 0, 1, 0, 0, CAP + 1, 0), 1);
    put(make_header(2, 0, 0, 0, 0, 8, 0), 1);
    put(make_header(3, 65535, 3, 0, 1, 10, 1), 1);
    put(make_header(3, 0, 3, 65535, 2047, 10, 2047), 1);
    put(make_header(3, 0, 3, 0, 3, 10, 2), 1);
    put(make_header(3, 0, 3, 0, 3, 10, 3), 1);
    put(data_beat(8'h5A), 1);
    // header mid-chunk aborts it, then a zero-length chunk and its repeat
    put(make_header(3, 1, 3, 3, 0, 10, 0), 1);
    put(make_header(3, 1, 3, 3, 0, 10, 0), 1);
    put(data_beat(8'h11), 1);
    put(make_header(3, 0, 3, 0, 1, 10, 1), 1);
    put(data_beat(8'h22), 1);
    put(make_header(3, 2, 3, 9, 1, 10, 1), 1);
    put(data_beat(8'h33), 1);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      in_quiet  <= ($urandom_range(0, 4) == 0);
      out_quiet <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 5))
            0: begin
              it      = any_item();
              it.func = FUNC_NONE;
              put(it, 0);
            end
            1: put(data_beat($urandom_range(0, 255)), 0);
            2: begin
              it      = any_item();
              it.func = FUNC_HEADER;
              put(it, 1);
            end
            3: put(make_header($urandom(), $urandom_range(0, 65535), 0, 0, 0,
                               $urandom_range(0, CAP), $urandom_range(0, 2047)), 1);
            4: begin
              if ($urandom_range(0, 1) == 0)
                put(make_header($urandom(), 0, $urandom_range(CHUNK_CAP + 1, 65535), 0, 0,
                                $urandom_range(0, CAP), 0), 1);
              else
                put(make_header($urandom(), 0, $urandom_range(1, CHUNK_CAP), 0, 0,
                                $urandom_range(CAP + 1, 65535), 0), 1);
            end
            default: if (stored_list.size() > 0) put(read_beat(pick_addr()), 1);
          endcase
        end
      end else begin
        seq      = ($urandom_range(0, 9) == 0) ? last_seq : $urandom();
        last_seq = seq;
        pick     = $urandom_range(0, 99);
        if (pick < 80) tot = $urandom_range(1, 6);
        else if (pick < 95) tot = $urandom_range(7, 24);
        else tot = $urandom_range(200, CHUNK_CAP);
        msz = ($urandom_range(0, 19) == 0) ? $urandom_range(1000, CAP) : $urandom_range(0, 48);
        for (int i = 0; i < tot; i++) begin
          if (tot <= 24 && msz <= 64 * tot) begin
            off_a[i] = i * msz / tot;
            len_a[i] = (i + 1) * msz / tot - off_a[i];
          end else begin
            len_a[i] = $urandom_range(0, 6);
            off_a[i] = $urandom_range(0, msz - len_a[i]);
          end
        end
        if (tot <= 24) begin
          n = tot;
          for (int i = 0; i < n; i++) order[i] = i;
          for (int i = n - 1; i > 0; i--) begin
            c        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[c];
            order[c] = tmp;
          end
        end else begin
          n = $urandom_range(4, 10);
          for (int i = 0; i < n; i++) order[i] = $urandom_range(0, tot - 1);
        end
        if (n > 1 && $urandom_range(0, 99) < 15) n--;
        for (int k = 0; k < n; k++) begin
          c = order[k];
          if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
              0: put(make_header(seq, $urandom_range(tot, 65535), tot, off_a[c], len_a[c],
                                 msz, 2047), 1);
              1: put(make_header(seq, c, tot, $urandom_range(msz - len_a[c] + 1, 65535),
                                 len_a[c], msz, 2047), 1);
              default: if (len_a[c] > 0)
                put(make_header(seq, c, tot, off_a[c], len_a[c], msz,
                                $urandom_range(0, len_a[c] - 1)), 1);
            endcase
          end
          reps = ($urandom_range(0, 15) == 0) ? 2 : 1;
          repeat (reps) begin
            avail = ($urandom_range(0, 3) == 0) ? len_a[c] : $urandom_range(len_a[c], 2047);
            put(make_header(seq, c, tot, off_a[c], len_a[c], msz, avail), 1);
            for (int b = 0; b < len_a[c]; b++) begin
              // cut the chunk short, the next header aborts it
              if ($urandom_range(0, 39) == 0) break;
              if ($urandom_range(0, 19) == 0 && stored_list.size() > 0)
                put(read_beat(pick_addr()), 1);
              put(data_beat($urandom_range(0, 255)), 1);
            end
            if ($urandom_range(0, 19) == 0) put(data_beat($urandom_range(0, 255)), 0);
          end
        end
        repeat ($urandom_range(0, 3))
          if (stored_list.size() > 0) put(read_beat(pick_addr()), 1);
      end
    end

    while (replies_done < items_made) @(posedge clk);
    repeat (20) @(posedge clk);
    if (reply_q.size() != 0) flag($sformatf("%0d results never arrived", reply_q.size()));
    $display("covered %0d beats: %0d headers taken, %0d bytes stored, %0d chunks closed",
             replies_done, status_hits[STS_HDR_OK], status_hits[STS_STORED],
             status_hits[STS_CHUNK]);
    $display("%0d messages complete, %0d rejected headers, %0d ignored, %0d reads, %0d errors",
             status_hits[STS_COMPLETE],
             status_hits[STS_BAD_INDEX] + status_hits[STS_BOUNDS] + status_hits[STS_SHORT]
               + status_hits[STS_CAPACITY],
             status_hits[STS_IGNORED], status_hits[STS_READ], errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
